### sv/hbs_pkg.sv
`timescale 1ns / 1ps

package hbs_pkg;

    // Field widths
    localparam int DIM_W   = 11;   // grid dimension registers
    localparam int POS_W   = 24;   // Q.8 positions and heights
    localparam int OUT_W   = 26;   // sampled height
    localparam int WORD_W  = 16;   // raw height word
    localparam int WADDR_W = 20;   // load address
    localparam int CFG_W   = 24;   // config data, widest register
    localparam int CIDX_W  = 3;    // config register index

    // Internal widths
    localparam int SQ_SHIFT = 3;                       // square size 8
    localparam int FRAC_W   = 8;                       // Q.8 fraction
    localparam int GQ_W     = DIM_W + FRAC_W;          // clamped grid coordinate
    localparam int CA_W     = 2 * DIM_W + 1;           // corner address
    localparam int WX_W     = FRAC_W + 1;              // one-axis weight
    localparam int WGT_W    = 2 * FRAC_W + 1;          // corner weight
    localparam int RAW_W    = WORD_W + 2 * FRAC_W;     // blended raw * 65536
    localparam int MAG_W    = POS_W + 1;               // |max - min|
    localparam int P_W      = RAW_W + MAG_W;           // raw * mag
    localparam int Q_W      = MAG_W;                   // scaled magnitude
    localparam int T_W      = Q_W + 1;                 // folded partial sum

    localparam logic [WX_W-1:0]   WEIGHT_ONE = WX_W'(256);
    localparam logic [WORD_W:0]   RAW_FULL   = (WORD_W + 1)'(65535);

    typedef enum logic [CIDX_W-1:0] {
        CFG_GRID_WIDTH  = 3'd0,
        CFG_GRID_HEIGHT = 3'd1,
        CFG_HEIGHT_MIN  = 3'd2,
        CFG_HEIGHT_MAX  = 3'd3,
        CFG_OFFSET      = 3'd4
    } cfg_index_t;

    typedef enum logic {
        MODE_WRITE  = 1'b0,
        MODE_SAMPLE = 1'b1
    } mode_t;

    // Corner lookup request: four addresses, their weights, and a pending load
    typedef struct packed {
        logic                        valid;
        logic                        usable;
        logic [3:0][CA_W-1:0]        addr;
        logic [3:0][WGT_W-1:0]       weight;
        logic                        wr_en;
        logic [WADDR_W-1:0]          wr_addr;
        logic [WORD_W-1:0]           wr_data;
    } corner_req_t;

    // Corner words with their weights, ready to blend
    typedef struct packed {
        logic                        valid;
        logic                        usable;
        logic [3:0][WORD_W-1:0]      word;
        logic [3:0][WGT_W-1:0]       weight;
    } corner_data_t;

endpackage

### sv/hbs_addr.sv
`timescale 1ns / 1ps

module hbs_addr
    import hbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     mode,
    input  logic [WADDR_W-1:0]       word_address,
    input  logic [WORD_W-1:0]        word_value,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic [DIM_W-1:0]         grid_width,
    input  logic [DIM_W-1:0]         grid_height,
    output corner_req_t              req
);

    // Floor-divide by the square size and clamp to 0 .. (dim-1)*256-1
    function automatic logic [GQ_W-1:0] grid_coord(
        input logic [POS_W-1:0] pos,
        input logic [DIM_W-1:0] dim
    );
        logic [GQ_W-1:0]           top;
        logic [POS_W-SQ_SHIFT-1:0] g;
        top = {dim - DIM_W'(1), FRAC_W'(0)} - GQ_W'(1);
        g   = pos[POS_W-1:SQ_SHIFT];
        if (pos[POS_W-1])
            grid_coord = '0;
        else if (g > (POS_W - SQ_SHIFT)'(top))
            grid_coord = top;
        else
            grid_coord = g[GQ_W-1:0];
    endfunction

    // Stage A: clamped grid coordinates
    logic              a_vld_reg, a_vld_next;
    logic              a_wr_reg, a_wr_next;
    logic              a_usable_reg, a_usable_next;
    logic [GQ_W-1:0]   a_gx_reg, a_gx_next;
    logic [GQ_W-1:0]   a_gz_reg, a_gz_next;
    logic [WADDR_W-1:0] a_waddr_reg;
    logic [WORD_W-1:0] a_wdata_reg;

    // Stage B: cell base address and fractions
    logic              b_vld_reg, b_wr_reg, b_usable_reg;
    logic [CA_W-1:0]   b_base_reg, b_base_next;
    logic [FRAC_W-1:0] b_fx_reg, b_fz_reg;
    logic [WADDR_W-1:0] b_waddr_reg;
    logic [WORD_W-1:0] b_wdata_reg;

    // Stage C: four corner addresses and weights
    logic              c_vld_reg, c_wr_reg, c_usable_reg;
    logic [3:0][CA_W-1:0]  c_addr_reg, c_addr_next;
    logic [3:0][WGT_W-1:0] c_wgt_reg, c_wgt_next;
    logic [WADDR_W-1:0] c_waddr_reg;
    logic [WORD_W-1:0] c_wdata_reg;

    logic [WGT_W-1:0]  wx0, wx1, wz0, wz1;

    // Split the beat into load and sample, clamp the position
    always_comb
    begin
        a_vld_next    = accept && (mode == MODE_SAMPLE);
        a_wr_next     = accept && (mode == MODE_WRITE);
        a_usable_next = (grid_width >= DIM_W'(2)) && (grid_height >= DIM_W'(2));
        a_gx_next     = grid_coord(pos_x, grid_width);
        a_gz_next     = grid_coord(pos_z, grid_height);
    end

    // Row times width plus column
    assign b_base_next = CA_W'(a_gz_reg[GQ_W-1:FRAC_W]) * CA_W'(grid_width)
                       + CA_W'(a_gx_reg[GQ_W-1:FRAC_W]);

    // Corner addresses and bilinear weights
    always_comb
    begin
        wx1 = WGT_W'(b_fx_reg);
        wz1 = WGT_W'(b_fz_reg);
        wx0 = WGT_W'(WEIGHT_ONE) - wx1;
        wz0 = WGT_W'(WEIGHT_ONE) - wz1;
        c_addr_next[0] = b_base_reg;
        c_addr_next[1] = b_base_reg + CA_W'(1);
        c_addr_next[2] = b_base_reg + CA_W'(grid_width);
        c_addr_next[3] = b_base_reg + CA_W'(grid_width) + CA_W'(1);
        c_wgt_next[0]  = wx0 * wz0;
        c_wgt_next[1]  = wx1 * wz0;
        c_wgt_next[2]  = wx0 * wz1;
        c_wgt_next[3]  = wx1 * wz1;
    end

    // Advance control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            a_wr_reg  <= 1'b0;
            b_vld_reg <= 1'b0;
            b_wr_reg  <= 1'b0;
            c_vld_reg <= 1'b0;
            c_wr_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            a_wr_reg  <= a_wr_next;
            b_vld_reg <= a_vld_reg;
            b_wr_reg  <= a_wr_reg;
            c_vld_reg <= b_vld_reg;
            c_wr_reg  <= b_wr_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        a_usable_reg <= a_usable_next;
        a_gx_reg     <= a_gx_next;
        a_gz_reg     <= a_gz_next;
        a_waddr_reg  <= word_address;
        a_wdata_reg  <= word_value;

        b_usable_reg <= a_usable_reg;
        b_base_reg   <= b_base_next;
        b_fx_reg     <= a_gx_reg[FRAC_W-1:0];
        b_fz_reg     <= a_gz_reg[FRAC_W-1:0];
        b_waddr_reg  <= a_waddr_reg;
        b_wdata_reg  <= a_wdata_reg;

        c_usable_reg <= b_usable_reg;
        c_addr_reg   <= c_addr_next;
        c_wgt_reg    <= c_wgt_next;
        c_waddr_reg  <= b_waddr_reg;
        c_wdata_reg  <= b_wdata_reg;
    end

    always_comb
    begin
        req.valid   = c_vld_reg;
        req.usable  = c_usable_reg;
        req.addr    = c_addr_reg;
        req.weight  = c_wgt_reg;
        req.wr_en   = c_wr_reg;
        req.wr_addr = c_waddr_reg;
        req.wr_data = c_wdata_reg;
    end

endmodule

### sv/hbs_store.sv
`timescale 1ns / 1ps

module hbs_store
    import hbs_pkg::*;
#(
    parameter int GRID_WORDS = 1048576
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  corner_req_t  req,
    output corner_data_t data
);

    localparam int ADDR_W = $clog2(GRID_WORDS);
    localparam int EXT_W  = (CA_W > ADDR_W + 1) ? CA_W : ADDR_W + 1;
    localparam logic [EXT_W-1:0] LIMIT = EXT_W'(GRID_WORDS);

    // Two copies, each read at two addresses per cycle
    logic [WORD_W-1:0] mem_a [GRID_WORDS];
    logic [WORD_W-1:0] mem_b [GRID_WORDS];

    logic [EXT_W-1:0]      wr_ext;
    logic                  wr_ok;
    logic [ADDR_W-1:0]     wr_idx;
    logic [3:0][EXT_W-1:0] rd_ext;
    logic [3:0]            rd_ok;
    logic [3:0][ADDR_W-1:0] rd_idx;

    logic [1:0][WORD_W-1:0] rd_a_reg, rd_b_reg;
    logic [3:0]             ok_reg;
    logic                   vld_reg;
    logic                   usable_reg;
    logic [3:0][WGT_W-1:0]  wgt_reg;

    // Range checks: loads beyond the store drop, corners beyond it read zero
    always_comb
    begin
        wr_ext = EXT_W'(req.wr_addr);
        wr_ok  = req.wr_en && (wr_ext < LIMIT);
        wr_idx = wr_ext[ADDR_W-1:0];
        for (int i = 0; i < 4; i++)
        begin
            rd_ext[i] = EXT_W'(req.addr[i]);
            rd_ok[i]  = rd_ext[i] < LIMIT;
            rd_idx[i] = rd_ext[i][ADDR_W-1:0];
        end
    end

    // Copy A serves the upper row of the cell
    always_ff @(posedge clk)
    begin
        if (wr_ok)
            mem_a[wr_idx] <= req.wr_data;
        if (rd_ok[0])
            rd_a_reg[0] <= mem_a[rd_idx[0]];
        if (rd_ok[1])
            rd_a_reg[1] <= mem_a[rd_idx[1]];
    end

    // Copy B serves the lower row of the cell
    always_ff @(posedge clk)
    begin
        if (wr_ok)
            mem_b[wr_idx] <= req.wr_data;
        if (rd_ok[2])
            rd_b_reg[0] <= mem_b[rd_idx[2]];
        if (rd_ok[3])
            rd_b_reg[1] <= mem_b[rd_idx[3]];
    end

    // Hold beat valid alongside the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= rd_ok;
        usable_reg <= req.usable;
        wgt_reg    <= req.weight;
    end

    always_comb
    begin
        data.valid   = vld_reg;
        data.usable  = usable_reg;
        data.weight  = wgt_reg;
        data.word[0] = ok_reg[0] ? rd_a_reg[0] : '0;
        data.word[1] = ok_reg[1] ? rd_a_reg[1] : '0;
        data.word[2] = ok_reg[2] ? rd_b_reg[0] : '0;
        data.word[3] = ok_reg[3] ? rd_b_reg[1] : '0;
    end

endmodule

### sv/hbs_blend.sv
`timescale 1ns / 1ps

module hbs_blend
    import hbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  corner_data_t             data,
    input  logic signed [POS_W-1:0]  height_min,
    input  logic signed [POS_W-1:0]  height_max,
    input  logic signed [POS_W-1:0]  placement_offset,
    output logic                     done,
    output logic signed [OUT_W-1:0]  height,
    output logic                     grid_usable
);

    localparam int NSTAGE = 6;
    localparam int PROD_FULL_W = WORD_W + WGT_W;

    logic [NSTAGE-1:0] vld_reg, vld_next;
    logic [NSTAGE-1:0] usable_reg;

    // Scale range, refreshed from the registers every cycle
    logic [MAG_W-1:0]  range_s;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              neg_reg;

    logic [3:0][RAW_W-1:0] prod_reg, prod_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic [P_W-1:0]    big_reg, big_next;
    logic [Q_W-1:0]    hi_reg, hi_next;
    logic [T_W-1:0]    t_reg, t_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [OUT_W-1:0]  height_reg, height_next;

    logic [PROD_FULL_W-1:0] prod_full [4];
    logic [RAW_W+1:0]  sum_full;
    logic [T_W-FRAC_W*2-1:0] t_hi;
    logic [WORD_W:0]   fold;
    logic [T_W-1:0]    q_full;
    logic [OUT_W-1:0]  scaled;

    // Magnitude and sign of max - min
    always_comb
    begin
        range_s  = {height_max[POS_W-1], height_max} - {height_min[POS_W-1], height_min};
        mag_next = range_s[MAG_W-1] ? (~range_s + MAG_W'(1)) : range_s;
    end

    // Weight each corner
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_full[i] = PROD_FULL_W'(data.word[i]) * PROD_FULL_W'(data.weight[i]);
            prod_next[i] = prod_full[i][RAW_W-1:0];
        end
    end

    // Sum the four weighted corners
    always_comb
    begin
        sum_full = (RAW_W + 2)'(prod_reg[0]) + (RAW_W + 2)'(prod_reg[1])
                 + (RAW_W + 2)'(prod_reg[2]) + (RAW_W + 2)'(prod_reg[3]);
        raw_next = sum_full[RAW_W-1:0];
    end

    // Scale by the height range
    assign big_next = P_W'(raw_reg) * P_W'(mag_reg);

    // Divide by 65535 * 65536: drop 16 bits, then fold 65536 = 65535 + 1 twice
    always_comb
    begin
        hi_next = big_reg[P_W-1:2*WORD_W];
        t_next  = T_W'(hi_next) + T_W'(big_reg[2*WORD_W-1:WORD_W]);
    end

    always_comb
    begin
        t_hi   = t_reg[T_W-1:WORD_W];
        fold   = (WORD_W + 1)'(t_hi) + (WORD_W + 1)'(t_reg[WORD_W-1:0]);
        q_full = T_W'(hi_reg) + T_W'(t_hi) + T_W'(fold >= RAW_FULL);
        q_next = q_full[Q_W-1:0];
    end

    // Apply sign, add min and offset; an unusable grid answers zero
    always_comb
    begin
        scaled = neg_reg ? (OUT_W'(0) - OUT_W'(q_reg)) : OUT_W'(q_reg);
        height_next = {{(OUT_W-POS_W){height_min[POS_W-1]}}, height_min} + scaled
                    + {{(OUT_W-POS_W){placement_offset[POS_W-1]}}, placement_offset};
        if (!usable_reg[NSTAGE-2])
            height_next = '0;
    end

    assign vld_next = {vld_reg[NSTAGE-2:0], data.valid};

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        usable_reg <= {usable_reg[NSTAGE-2:0], data.usable};
        mag_reg    <= mag_next;
        neg_reg    <= range_s[MAG_W-1];
        prod_reg   <= prod_next;
        raw_reg    <= raw_next;
        big_reg    <= big_next;
        hi_reg     <= hi_next;
        t_reg      <= t_next;
        q_reg      <= q_next;
        height_reg <= height_next;
    end

    assign done        = vld_reg[NSTAGE-1];
    assign height      = height_reg;
    assign grid_usable = usable_reg[NSTAGE-1];

endmodule

### sv/heightmap_bilinear_sampler_core.sv
`timescale 1ns / 1ps
// Heightmap bilinear sampler.
// Input: a beat is taken at a rising edge with start high and busy low. busy
// stays low, so a beat can be given every cycle. mode selects a load (store
// word_value at word_address) or a sample (pos_x, pos_z in Q.8 world units).
// Output: each sample yields one result; done is high for exactly one cycle
// with height and grid_usable valid. Loads yield nothing.
// A sample passes the address stages, the store read and the blend stages
// before it is reported. Throughput is one beat per cycle, set by the height
// store, which is kept in two copies with two read ports each so all four cell
// corners are read in the same cycle. Loads travel the same pipeline, so a
// sample sees every load given before it.
// The receiver cannot hold results off; none are needed since the pipeline
// never stalls.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge; write
// only while no sample is in flight.
// Reset clears the pipeline and loads register defaults (dimensions zero,
// offset 1280). Store contents are undefined until loaded; no clearing pass.
module heightmap_bilinear_sampler_core
    import hbs_pkg::*;
#(
    parameter int GRID_WORDS = 1048576
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     mode,
    input  logic [WADDR_W-1:0]       word_address,
    input  logic [WORD_W-1:0]        word_value,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic                     cfg_we,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    output logic                     done,
    output logic signed [OUT_W-1:0]  height,
    output logic                     grid_usable
);

    logic [DIM_W-1:0]         grid_width_reg;
    logic [DIM_W-1:0]         grid_height_reg;
    logic signed [POS_W-1:0]  height_min_reg;
    logic signed [POS_W-1:0]  height_max_reg;
    logic signed [POS_W-1:0]  offset_reg;

    logic          accept;
    corner_req_t   req;
    corner_data_t  corners;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= '0;
            grid_height_reg <= '0;
            height_min_reg  <= '0;
            height_max_reg  <= '0;
            offset_reg      <= POS_W'(1280);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT_MIN:  height_min_reg  <= cfg_data;
                CFG_HEIGHT_MAX:  height_max_reg  <= cfg_data;
                CFG_OFFSET:      offset_reg      <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    hbs_addr u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (mode),
        .word_address (word_address),
        .word_value   (word_value),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .grid_width   (grid_width_reg),
        .grid_height  (grid_height_reg),
        .req          (req)
    );

    hbs_store #(
        .GRID_WORDS (GRID_WORDS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .data  (corners)
    );

    hbs_blend u_blend (
        .clk              (clk),
        .rst_n            (rst_n),
        .data             (corners),
        .height_min       (height_min_reg),
        .height_max       (height_max_reg),
        .placement_offset (offset_reg),
        .done             (done),
        .height           (height),
        .grid_usable      (grid_usable)
    );

endmodule

### sim/tb_heightmap_bilinear_sampler_core.sv
`timescale 1ns / 1ps

module tb_heightmap_bilinear_sampler_core;
    import hbs_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int LATENCY       = 10;
    localparam int SETTLE_CYCLES = 2 * LATENCY;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int PHASES        = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 200;

    localparam logic [CIDX_W-1:0]      CFG_SPARE_FIRST = 3'd5;
    localparam logic [CIDX_W-1:0]      CFG_SPARE_LAST  = 3'd7;
    localparam logic signed [POS_W-1:0] Q8_MIN = 24'sh800000;
    localparam logic signed [POS_W-1:0] Q8_MAX = 24'sh7FFFFF;
    localparam longint unsigned SCALE_DIV = 64'd65535 * 64'd65536;

    typedef struct {
        logic signed [OUT_W-1:0] height;
        logic                    usable;
    } sample_result_t;

    typedef enum bit [1:0] {
        STEP_REG,
        STEP_LOAD,
        STEP_SAMPLE
    } step_kind_t;

    typedef struct {
        step_kind_t              kind;
        logic [CIDX_W-1:0]       index;
        logic [CFG_W-1:0]        data;
        logic [WADDR_W-1:0]      addr;
        logic [WORD_W-1:0]       word;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] pz;
        bit                      known;
        logic signed [OUT_W-1:0] known_height;
        logic                    known_usable;
    } plan_step_t;

    // DUT ports; the driven inputs are known from time zero
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    mode = MODE_WRITE;
    logic [WADDR_W-1:0]      word_address = '0;
    logic [WORD_W-1:0]       word_value = '0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_z = '0;
    logic                    cfg_we = 1'b0;
    logic [CIDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    done;
    logic signed [OUT_W-1:0] height;
    logic                    grid_usable;

    // Register mirror, reset values
    logic [DIM_W-1:0]        grid_w = '0;
    logic [DIM_W-1:0]        grid_h = '0;
    logic signed [POS_W-1:0] hmin = '0;
    logic signed [POS_W-1:0] hmax = '0;
    logic signed [POS_W-1:0] hoffset = 24'sd1280;

    logic [WORD_W-1:0] height_mem [int unsigned];
    sample_result_t    expected_heights [$];
    plan_step_t        directed_plan [$];

    int idle_pct = 14;
    int mismatches = 0;
    int n_checked = 0;
    int n_loads = 0;
    int n_samples = 0;
    int n_usable = 0;
    int n_reg_writes = 0;
    int n_beats = 0;
    int cycle_count = 0;

    heightmap_bilinear_sampler_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .word_address (word_address),
        .word_value   (word_value),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .height       (height),
        .grid_usable  (grid_usable)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Clamped grid coordinate in Q.8 cells, 0 .. (dim-1)*256-1
    function automatic longint clamp_grid(logic signed [POS_W-1:0] pos,
                                          logic [DIM_W-1:0] dim);
        longint top;
        longint g;
        top = longint'(dim) * 256 - 257;
        g = longint'(pos) >>> SQ_SHIFT;
        if (g < 0)
            g = 0;
        if (g > top)
            g = top;
        return g;
    endfunction

    function automatic longint corner_base(logic signed [POS_W-1:0] px,
                                           logic signed [POS_W-1:0] pz);
        return (clamp_grid(pz, grid_h) >> FRAC_W) * longint'(grid_w)
             + (clamp_grid(px, grid_w) >> FRAC_W);
    endfunction

    function automatic longint unsigned stored_word(longint addr);
        if (height_mem.exists(addr))
            return height_mem[addr];
        return 0;
    endfunction

    // Blend four corners, scale by the height range, add min and offset
    function automatic sample_result_t bilinear_height(logic signed [POS_W-1:0] px,
                                                       logic signed [POS_W-1:0] pz);
        sample_result_t   r;
        longint           fx;
        longint           fz;
        longint           base;
        longint           w;
        longint           span;
        longint           total;
        longint unsigned  raw;
        longint unsigned  mag;
        longint unsigned  q;
        r.height = '0;
        r.usable = 1'b0;
        if (grid_w < 2 || grid_h < 2)
            return r;
        fx = clamp_grid(px, grid_w) & 255;
        fz = clamp_grid(pz, grid_h) & 255;
        w = longint'(grid_w);
        base = corner_base(px, pz);
        raw = stored_word(base) * (256 - fx) * (256 - fz)
            + stored_word(base + 1) * fx * (256 - fz)
            + stored_word(base + w) * (256 - fx) * fz
            + stored_word(base + w + 1) * fx * fz;
        span = longint'(hmax) - longint'(hmin);
        mag = (span < 0) ? -span : span;
        q = (raw * mag) / SCALE_DIV;
        total = longint'(hmin) + ((span < 0) ? -longint'(q) : longint'(q))
              + longint'(hoffset);
        r.height = total[OUT_W-1:0];
        r.usable = 1'b1;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(bit full);
        if (full)
            return DIM_W'(1024);
        case ($urandom_range(19))
            0, 1: return DIM_W'($urandom_range(1));
            2: return DIM_W'(1024);
            3, 4: return DIM_W'($urandom_range(1024, 2));
            default: return DIM_W'($urandom_range(12, 2));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_q8();
        case ($urandom_range(9))
            0: return Q8_MIN;
            1: return Q8_MAX;
            2, 3, 4: return CFG_W'(int'($urandom_range(8192)) - 4096);
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] pick_pos(logic [DIM_W-1:0] dim);
        case ($urandom_range(9))
            0, 1: return POS_W'($urandom);
            2: return POS_W'(-int'($urandom_range(4000)));
            3: return POS_W'(int'($urandom_range(dim)) * 2048);
            default: return POS_W'($urandom_range(int'(dim) * 2048 + 2000));
        endcase
    endfunction

    function automatic void plan_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        plan_step_t s;
        s.kind = STEP_REG;
        s.index = idx;
        s.data = data;
        directed_plan = {directed_plan, s};
    endfunction

    function automatic void plan_load(logic [WADDR_W-1:0] addr, logic [WORD_W-1:0] word);
        plan_step_t s;
        s.kind = STEP_LOAD;
        s.addr = addr;
        s.word = word;
        directed_plan = {directed_plan, s};
    endfunction

    function automatic void plan_sample(logic signed [POS_W-1:0] px,
                                        logic signed [POS_W-1:0] pz, bit known,
                                        logic signed [OUT_W-1:0] kh, logic ku);
        plan_step_t s;
        s.kind = STEP_SAMPLE;
        s.px = px;
        s.pz = pz;
        s.known = known;
        s.known_height = kh;
        s.known_usable = ku;
        directed_plan = {directed_plan, s};
    endfunction

    // Drive one beat, hold it until taken, then update the prediction
    task automatic send_beat(mode_t m, logic [WADDR_W-1:0] addr, logic [WORD_W-1:0] word,
                             logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] pz,
                             bit known, logic signed [OUT_W-1:0] kh, logic ku);
        sample_result_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        mode = m;
        word_address = addr;
        word_value = word;
        pos_x = px;
        pos_z = pz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_beats++;
        if (m == MODE_WRITE)
        begin
            height_mem[addr] = word;
            n_loads++;
        end
        else
        begin
            res = bilinear_height(px, pz);
            if (known)
            begin
                res.height = kh;
                res.usable = ku;
            end
            expected_heights = {expected_heights, res};
            n_samples++;
            if (res.usable)
                n_usable++;
        end
    endtask

    // Load any unwritten corner of the addressed cell, then sample
    task automatic send_sample(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] pz,
                               bit known, logic signed [OUT_W-1:0] kh, logic ku);
        longint base;
        longint a;
        if (grid_w >= 2 && grid_h >= 2)
        begin
            base = corner_base(px, pz);
            for (int k = 0; k < 4; k++)
            begin
                a = base + ((k & 1) ? 1 : 0) + ((k & 2) ? longint'(grid_w) : 0);
                if (!height_mem.exists(a))
                    send_beat(MODE_WRITE, WADDR_W'(a), random_word(), POS_W'($urandom),
                              POS_W'($urandom), 1'b0, '0, 1'b0);
            end
        end
        send_beat(MODE_SAMPLE, WADDR_W'($urandom), WORD_W'($urandom), px, pz,
                  known, kh, ku);
    endtask

    // Stop sending and wait for every pending result, plus extra cycles
    task automatic settle(int extra);
        @(negedge clk);
        start = 1'b0;
        while (expected_heights.size() != 0)
            @(negedge clk);
        repeat (extra)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        start = 1'b0;
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_GRID_WIDTH:  grid_w = data[DIM_W-1:0];
            CFG_GRID_HEIGHT: grid_h = data[DIM_W-1:0];
            CFG_HEIGHT_MIN:  hmin = data;
            CFG_HEIGHT_MAX:  hmax = data;
            CFG_OFFSET:      hoffset = data;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_results
        sample_result_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (expected_heights.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: height %0d usable %0b",
                             height, grid_usable);
            end
            else
            begin
                want = expected_heights.pop_front();
                if (height !== want.height || grid_usable !== want.usable)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: expected height %0d usable %0b, got %0d %0b",
                                 n_checked, want.height, want.usable, height, grid_usable);
                end
                n_checked++;
            end
        end
    end

    // Guard against a hang
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        plan_step_t step;
        bit         prev_reg;
        bit         halted;
        int         per_phase;
        int         item_no;
        int         random_start;

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset dimensions are zero, so no grid is usable yet
        plan_sample('0, '0, 1'b1, '0, 1'b0);
        plan_reg(CFG_GRID_WIDTH, 24'd2047);
        plan_reg(CFG_GRID_HEIGHT, 24'd1);
        plan_sample(Q8_MAX, Q8_MIN, 1'b1, '0, 1'b0);
        plan_reg(CFG_GRID_WIDTH, 24'd2);
        plan_reg(CFG_GRID_HEIGHT, 24'd0);
        plan_sample(24'sd1000, 24'sd1000, 1'b1, '0, 1'b0);
        // Smallest usable grid, flat zero: only the default offset remains
        plan_reg(CFG_GRID_HEIGHT, 24'd2);
        for (int a = 0; a < 4; a++)
            plan_load(WADDR_W'(a), 16'd0);
        plan_sample('0, '0, 1'b1, 26'sd1280, 1'b1);
        // Full-scale words over the widest range
        for (int a = 0; a < 4; a++)
            plan_load(WADDR_W'(a), 16'hFFFF);
        plan_reg(CFG_HEIGHT_MIN, Q8_MIN);
        plan_reg(CFG_HEIGHT_MAX, Q8_MAX);
        plan_reg(CFG_OFFSET, 24'd0);
        plan_sample(Q8_MAX, Q8_MIN, 1'b1, 26'sd8388607, 1'b1);
        plan_reg(CFG_OFFSET, Q8_MAX);
        plan_sample(24'sd2040, 24'sd2040, 1'b1, 26'sd16777214, 1'b1);
        plan_reg(CFG_HEIGHT_MAX, Q8_MIN);
        plan_reg(CFG_OFFSET, Q8_MIN);
        plan_sample('0, 24'sd2040, 1'b1, -26'sd16777216, 1'b1);
        // Distinct corners, positive range; spare indexes must be ignored
        plan_load(20'd0, 16'd100);
        plan_load(20'd1, 16'd40000);
        plan_load(20'd2, 16'd7);
        plan_load(20'd3, 16'd65535);
        plan_reg(CFG_HEIGHT_MIN, -24'sd1000);
        plan_reg(CFG_HEIGHT_MAX, 24'sd5000);
        plan_reg(CFG_OFFSET, 24'sd1280);
        for (int s = CFG_SPARE_FIRST; s <= CFG_SPARE_LAST; s++)
            plan_reg(CIDX_W'(s), 24'hFFFFFF);
        plan_sample(24'sd1024, 24'sd512, 1'b0, '0, 1'b0);
        plan_sample(-24'sd8, 24'sd2040, 1'b0, '0, 1'b0);
        // Negative range truncates toward zero
        plan_reg(CFG_HEIGHT_MIN, 24'sd5000);
        plan_reg(CFG_HEIGHT_MAX, -24'sd1000);
        plan_sample(24'sd1023, 24'sd1537, 1'b0, '0, 1'b0);
        plan_sample(24'sd2040, 24'sd2040, 1'b0, '0, 1'b0);
        // Largest grid, far corner touches the last word address
        plan_load(20'hFFFFF, 16'hFFFF);
        plan_reg(CFG_GRID_WIDTH, 24'd1024);
        plan_reg(CFG_GRID_HEIGHT, 24'd1024);
        plan_sample(Q8_MAX, Q8_MAX, 1'b0, '0, 1'b0);
        plan_sample(Q8_MIN, Q8_MAX, 1'b0, '0, 1'b0);

        // Walk the directed table; drain before each run of register writes
        prev_reg = 1'b0;
        foreach (directed_plan[k])
        begin
            step = directed_plan[k];
            case (step.kind)
                STEP_REG:
                begin
                    if (!prev_reg)
                        settle(SETTLE_CYCLES);
                    write_reg(step.index, step.data);
                end
                STEP_LOAD:
                    send_beat(MODE_WRITE, step.addr, step.word, POS_W'($urandom),
                              POS_W'($urandom), 1'b0, '0, 1'b0);
                default:
                    send_sample(step.px, step.pz, step.known, step.known_height,
                                step.known_usable);
            endcase
            prev_reg = (step.kind == STEP_REG);
        end

        // Random phases, each with its own register setting; count every beat
        per_phase = RANDOM_ITEMS / PHASES;
        random_start = n_beats;
        for (int p = 0; p < PHASES; p++)
        begin
            settle(SETTLE_CYCLES);
            write_reg(CFG_GRID_WIDTH, CFG_W'(pick_dim(p == 2)));
            write_reg(CFG_GRID_HEIGHT, CFG_W'(pick_dim(p == 2)));
            write_reg(CFG_HEIGHT_MIN, pick_q8());
            write_reg(CFG_HEIGHT_MAX, pick_q8());
            write_reg(CFG_OFFSET, pick_q8());
            if ($urandom_range(3) == 0)
                write_reg(CIDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                          CFG_W'($urandom));
            halted = 1'b0;
            while (n_beats - random_start < (p + 1) * per_phase)
            begin
                item_no = n_beats - random_start;
                if (item_no < RANDOM_ITEMS / 3)
                    idle_pct = 14;
                else if (item_no < 2 * RANDOM_ITEMS / 3)
                    idle_pct = 58;
                else
                    idle_pct = 0;
                // Hold off mid-phase until the pipeline has emptied
                if (!halted && item_no >= p * per_phase + per_phase / 2)
                begin
                    settle(0);
                    halted = 1'b1;
                end
                if ($urandom_range(9) < 3)
                begin
                    if ($urandom_range(1) == 1 && grid_w != 0 && grid_h != 0)
                        send_beat(MODE_WRITE,
                                  WADDR_W'($urandom_range(int'(grid_w) * int'(grid_h) - 1)),
                                  random_word(), POS_W'($urandom), POS_W'($urandom),
                                  1'b0, '0, 1'b0);
                    else
                        send_beat(MODE_WRITE, WADDR_W'($urandom), random_word(),
                                  POS_W'($urandom), POS_W'($urandom), 1'b0, '0, 1'b0);
                end
                else
                begin
                    send_sample(pick_pos(grid_w), pick_pos(grid_h), 1'b0, '0, 1'b0);
                end
            end
        end

        // Drain, allow stray beats to show up, then report
        @(negedge clk);
        start = 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && expected_heights.size() != 0; c++)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (expected_heights.size() != 0)
            $display("%0d samples never produced a result", expected_heights.size());
        mismatches += expected_heights.size();

        $display("covered %0d loads and %0d samples, %0d of them on usable grids",
                 n_loads, n_samples, n_usable);
        $display("%0d register writes over %0d random settings; %0d results compared",
                 n_reg_writes, PHASES, n_checked);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
sv/hbs_pkg.sv
sv/hbs_addr.sv
sv/hbs_store.sv
sv/hbs_blend.sv
sv/heightmap_bilinear_sampler_core.sv
sim/tb_heightmap_bilinear_sampler_core.sv
